// ===== hw/rtl/flow_hash_load_balancer_unit_defines.svh =====
// Assertion macros shared by the flow hash load balancer RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FLOW_HASH_LOAD_BALANCER_UNIT_DEFINES_SVH
`define FLOW_HASH_LOAD_BALANCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHLB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fhlb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FHLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fhlb: next-cycle check failed");

`endif

// ===== hw/rtl/fhlb_pkg.sv =====
// Shared types and constants for the flow hash load balancer.
// No dependencies; imported by every module of the block.
`default_nettype none

package fhlb_pkg;

  // Multiplicative hash constant applied to the flow value.
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // Number of finished-frame descriptors held between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic {
    REG_BALANCE_MODE = 1'b0,
    REG_PORT_COUNT   = 1'b1
  } reg_index_e;

  // One parsed frame, handed from the front to the back.
  typedef struct packed {
    logic [31:0] flow;
    logic [15:0] len;
  } desc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fhlb_front.sv =====
// Front end: takes frame bytes, captures the header fields and builds one
// descriptor per frame. Depends on fhlb_pkg.
`default_nettype none

module fhlb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    frame_byte_i,
  input  wire logic          frame_end_i,
  input  wire logic          full_i,
  output logic               push_o,
  output fhlb_pkg::desc_t    desc_o
);
  import fhlb_pkg::*;

  localparam logic [15:0] OffTypeHi = 16'd12;
  localparam logic [15:0] OffTypeLo = 16'd13;
  localparam logic [15:0] OffIhl    = 16'd14;
  localparam logic [15:0] OffProto  = 16'd23;
  localparam logic [15:0] OffSrc    = 16'd26;
  localparam logic [15:0] OffDst    = 16'd30;
  localparam logic [15:0] OffEnd    = 16'd34;
  localparam logic [15:0] LenMax    = 16'hFFFF;
  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  logic [15:0] offset_q, offset_d;
  logic [15:0] ether_q, ether_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [31:0] ports_q, ports_d;
  logic [15:0] l4_w, l4_diff_w;
  logic [1:0]  port_lane_w;
  logic [31:0] byte_w;
  logic [31:0] hash_w;
  logic        accept_w;

  assign in_ready_o = !full_i;
  assign accept_w   = in_valid_i && in_ready_o;
  assign push_o     = accept_w && frame_end_i;
  assign byte_w     = {24'b0, frame_byte_i};

  // Field capture for the byte at the current offset.
  always_comb begin
    ether_d = ether_q;
    if (offset_q == OffTypeHi) begin
      ether_d = {frame_byte_i, ether_q[7:0]};
    end
    if (offset_q == OffTypeLo) begin
      ether_d = {ether_q[15:8], frame_byte_i};
    end
    ihl_d   = (offset_q == OffIhl) ? frame_byte_i[3:0] : ihl_q;
    proto_d = (offset_q == OffProto) ? frame_byte_i : proto_q;

    src_d = src_q;
    if (offset_q >= OffSrc && offset_q < OffDst) begin
      src_d = src_q | (byte_w << {3'(offset_q - OffSrc), 3'b000});
    end
    dst_d = dst_q;
    if (offset_q >= OffDst && offset_q < OffEnd) begin
      dst_d = dst_q | (byte_w << {3'(offset_q - OffDst), 3'b000});
    end

    // The port pair sits at the start of the transport header; the two
    // 16-bit halves are swapped as they land.
    l4_w        = OffIhl + {10'b0, ihl_d, 2'b00};
    l4_diff_w   = offset_q - l4_w;
    port_lane_w = l4_diff_w[1:0] + 2'd2;
    ports_d     = ports_q;
    if (offset_q >= l4_w && l4_diff_w < 16'd4) begin
      ports_d = ports_q | (byte_w << {port_lane_w, 3'b000});
    end

    offset_d = (offset_q < LenMax) ? offset_q + 16'd1 : LenMax;
  end

  // Flow value of the frame as it stands after this byte.
  always_comb begin
    hash_w = src_d ^ dst_d;
    if (proto_d == ProtoTcp || proto_d == ProtoUdp) begin
      hash_w = hash_w ^ ports_d;
    end
    desc_o.flow = (ether_d == EthIpv4) ? hash_w : 32'b0;
    desc_o.len  = offset_d;
  end

  // Per-frame state, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      ether_q  <= '0;
      ihl_q    <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      ports_q  <= '0;
    end else if (accept_w) begin
      if (frame_end_i) begin
        offset_q <= '0;
        ether_q  <= '0;
        ihl_q    <= '0;
        proto_q  <= '0;
        src_q    <= '0;
        dst_q    <= '0;
        ports_q  <= '0;
      end else begin
        offset_q <= offset_d;
        ether_q  <= ether_d;
        ihl_q    <= ihl_d;
        proto_q  <= proto_d;
        src_q    <= src_d;
        dst_q    <= dst_d;
        ports_q  <= ports_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fhlb_queue.sv =====
// Short descriptor queue between the front and back ends.
// Depends on fhlb_pkg for the descriptor type and depth.
`default_nettype none

module fhlb_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  fhlb_pkg::desc_t    desc_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output fhlb_pkg::desc_t    desc_o,
  output logic               empty_o
);
  import fhlb_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t            slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign desc_o  = slots_q[rd_ptr_q];

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fhlb_back.sv =====
// Back end: hashes or rotates, reduces modulo the port count bit by bit,
// keeps the running totals and holds the result beat. Depends on fhlb_pkg.
`default_nettype none

module fhlb_back #(
  parameter int unsigned MAX_PORTS = 8,
  localparam int unsigned NW = $clog2(MAX_PORTS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  fhlb_pkg::desc_t    desc_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  input  wire logic          mode_i,
  input  wire logic [NW-1:0] ports_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [2:0]         chosen_port_o,
  output logic [15:0]        frame_length_o,
  output logic [47:0]        frames_seen_o,
  output logic [47:0]        bytes_seen_o
);
  import fhlb_pkg::*;

  localparam int unsigned RW = NW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [31:0]     flow_q;
  logic [15:0]     len_q;
  logic [31:0]     div_q;
  logic [RW-1:0]   rem_q, rem_d, rem_sh_w;
  logic [4:0]      bit_q;
  logic [31:0]     rotor_q;
  logic [47:0]     frame_tot_q, byte_tot_q;
  logic [31:0]     hash_w;
  logic            load_w;
  logic            out_valid_q;
  logic [2:0]      chosen_q;
  logic [15:0]     len_out_q;
  logic [47:0]     frames_out_q, bytes_out_q;

  assign pop_o          = (state_q == ST_IDLE) && !empty_i;
  assign hash_w         = flow_q * HASH_MULT;
  assign load_w         = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign chosen_port_o  = chosen_q;
  assign frame_length_o = len_out_q;
  assign frames_seen_o  = frames_out_q;
  assign bytes_seen_o   = bytes_out_q;

  // One restoring remainder step per cycle, dividend bits taken MSB first.
  always_comb begin
    rem_sh_w = {rem_q[RW-2:0], div_q[31]};
    rem_d    = (rem_sh_w >= {1'b0, ports_i}) ? rem_sh_w - {1'b0, ports_i} : rem_sh_w;
  end

  // Sequencer, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flow_q       <= '0;
      len_q        <= '0;
      div_q        <= '0;
      rem_q        <= '0;
      bit_q        <= '0;
      rotor_q      <= '0;
      frame_tot_q  <= '0;
      byte_tot_q   <= '0;
      out_valid_q  <= 1'b0;
      chosen_q     <= '0;
      len_out_q    <= '0;
      frames_out_q <= '0;
      bytes_out_q  <= '0;
    end else begin
      // The result register refills from the back end or empties on a taken beat.
      if (load_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            flow_q  <= desc_i.flow;
            len_q   <= desc_i.len;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // The rotor only moves in round-robin mode.
          if (mode_i) begin
            div_q <= hash_w;
          end else begin
            div_q   <= rotor_q;
            rotor_q <= rotor_q + 32'd1;
          end
          rem_q   <= '0;
          bit_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_d;
          div_q <= {div_q[30:0], 1'b0};
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_w) begin
            chosen_q     <= 3'(rem_q);
            len_out_q    <= len_q;
            frames_out_q <= frame_tot_q + 48'd1;
            bytes_out_q  <= byte_tot_q + {32'b0, len_q};
            frame_tot_q  <= frame_tot_q + 48'd1;
            byte_tot_q   <= byte_tot_q + {32'b0, len_q};
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flow_hash_load_balancer_unit.sv =====
// Top level of the flow hash load balancer: configuration port, front end,
// descriptor queue and back end. Depends on fhlb_pkg and the defines header.
//
// Usage:
// - Frame bytes enter on the in channel, one beat per byte, with
//   frame_end_i high on the last byte. One result beat per frame leaves on
//   the out channel: chosen port, frame length and the running totals.
// - The front end takes one byte per cycle while the queue is not full. The
//   back end pops a descriptor, does the hash multiply, runs the bit-serial
//   remainder by the port count one dividend bit per step and loads the result.
// - With the back end idle, the result beat is offered after the frame's push,
//   pop, hash multiply, remainder steps and result load, in that order.
// - A four-entry queue holds finished frames, so frames of 35 bytes or more
//   stream at one byte per cycle; bursts of shorter frames are absorbed
//   until the queue fills, then in_ready_o drops.
// - When the receiver stalls, the result beat holds, the back end finishes
//   the next frame and waits, and the queue fills before the input stalls.
// - Reset clears the frame parser, the queue, the rotor, the totals and the
//   registers (round robin, two ports). Write registers over the APB-style port
//   only while the block is idle; the block does not enforce this. pready is always high.
`default_nettype none

`include "flow_hash_load_balancer_unit_defines.svh"

module flow_hash_load_balancer_unit #(
  parameter int unsigned MAX_PORTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       chosen_port_o,
  output logic [15:0]      frame_length_o,
  output logic [47:0]      frames_seen_o,
  output logic [47:0]      bytes_seen_o
);
  import fhlb_pkg::*;

  localparam int unsigned NW = $clog2(MAX_PORTS + 1);

  logic            mode_q;
  logic [3:0]      port_count_q;
  logic [NW-1:0]   ports_w;
  logic            wr_w;
  reg_index_e      reg_w;
  logic            push_w, pop_w, full_w, empty_w;
  desc_t           front_desc_w, back_desc_w;
  logic            out_beat_w;
  logic [47:0]     frames_next_w, bytes_base_w;

  assign pready = 1'b1;
  assign wr_w   = psel && penable && pwrite && pready;
  assign reg_w  = reg_index_e'(paddr[2]);

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      port_count_q <= 4'd2;
    end else if (wr_w) begin
      case (reg_w)
        REG_BALANCE_MODE: mode_q       <= pwdata[0];
        REG_PORT_COUNT:   port_count_q <= pwdata[3:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_w)
      REG_BALANCE_MODE: prdata = {31'b0, mode_q};
      REG_PORT_COUNT:   prdata = {28'b0, port_count_q};
      default:          prdata = '0;
    endcase
  end

  // Ports in use, clamped to two through the maximum.
  always_comb begin
    if (port_count_q < 4'd2) begin
      ports_w = NW'(2);
    end else if (32'(port_count_q) > MAX_PORTS) begin
      ports_w = NW'(MAX_PORTS);
    end else begin
      ports_w = NW'(port_count_q);
    end
  end

  fhlb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_byte_i (frame_byte_i),
    .frame_end_i  (frame_end_i),
    .full_i       (full_w),
    .push_o       (push_w),
    .desc_o       (front_desc_w)
  );

  fhlb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .desc_i  (front_desc_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .desc_o  (back_desc_w),
    .empty_o (empty_w)
  );

  fhlb_back #(
    .MAX_PORTS (MAX_PORTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_i         (back_desc_w),
    .empty_i        (empty_w),
    .pop_o          (pop_w),
    .mode_i         (mode_q),
    .ports_i        (ports_w),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chosen_port_o  (chosen_port_o),
    .frame_length_o (frame_length_o),
    .frames_seen_o  (frames_seen_o),
    .bytes_seen_o   (bytes_seen_o)
  );

  // Helpers for the total checks below.
  assign out_beat_w    = out_valid_o && out_ready_i;
  assign frames_next_w = frames_seen_o + 48'd1;
  assign bytes_base_w  = bytes_seen_o - {32'b0, frame_length_o};

  // Consecutive result beats carry totals that advance by exactly one frame.
  `FHLB_ASSERT_NEXT(a_frames_step, out_beat_w, !out_valid_o || frames_seen_o == $past(frames_next_w))
  `FHLB_ASSERT_NEXT(a_bytes_step, out_beat_w, !out_valid_o || bytes_base_w == $past(bytes_seen_o))
  // Every frame has at least its last byte.
  `FHLB_ASSERT_NOW(a_len_nonzero, out_valid_o, frame_length_o != 16'd0)

endmodule

`default_nettype wire

// ===== tb/flow_hash_load_balancer_unit_test.sv =====
// Self-checking testbench for flow_hash_load_balancer_unit: sends Ethernet frames byte by
// byte, predicts the port choice, length and running totals of every frame, and checks them.
// Depends on fhlb_pkg and the RTL of the unit; needs no files or arguments.
module flow_hash_load_balancer_unit_test;
  import fhlb_pkg::*;

  localparam int unsigned PORT_LIMIT = 8;
  localparam logic [31:0] GOLDEN_RATIO_MULT = 32'd2654435761;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic BALANCE_ROUND_ROBIN = 1'b0;
  localparam logic BALANCE_FLOW_HASH = 1'b1;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SEGMENT_BYTES = 30;
  localparam int unsigned MAX_PRINTED_MISMATCHES = 50;

  // One per-frame result as it leaves the block.
  typedef struct packed {
    logic [2:0]  port;
    logic [15:0] len;
    logic [47:0] frames;
    logic [47:0] bytes;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i = '0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  chosen_port_o;
  logic [15:0] frame_length_o;
  logic [47:0] frames_seen_o;
  logic [47:0] bytes_seen_o;

  flow_hash_load_balancer_unit #(
    .MAX_PORTS(PORT_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_byte_i  (frame_byte_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chosen_port_o (chosen_port_o),
    .frame_length_o(frame_length_o),
    .frames_seen_o (frames_seen_o),
    .bytes_seen_o  (bytes_seen_o)
  );

  // Stimulus controls, bookkeeping and the frame under construction.
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   rx_holds_asked = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   frames_sent = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  logic [7:0]    frame_buf[$];
  frame_result_t pending_results[$];

  // Predicted configuration and parser state of the block.
  logic        cfg_flow_hash = BALANCE_ROUND_ROBIN;
  logic [3:0]  cfg_port_count = 4'd2;
  logic [15:0] parse_offset = '0;
  logic [15:0] parse_ether_type = '0;
  logic [3:0]  parse_ihl = '0;
  logic [7:0]  parse_proto = '0;
  logic [31:0] parse_src = '0;
  logic [31:0] parse_dst = '0;
  logic [31:0] parse_ports = '0;
  logic [31:0] rr_rotor = '0;
  logic [47:0] total_frames = '0;
  logic [47:0] total_bytes = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the parser by one accepted byte; a closing byte yields one expected result.
  function automatic void absorb_frame_byte(input logic [7:0] b, input logic last);
    int unsigned   pos;
    int unsigned   l4;
    int unsigned   lanes;
    logic [31:0]   flow;
    logic [15:0]   len;
    frame_result_t res;
    pos = parse_offset;
    if (pos == 12) parse_ether_type[15:8] = b;
    if (pos == 13) parse_ether_type[7:0] = b;
    if (pos == 14) parse_ihl = b[3:0];
    if (pos == 23) parse_proto = b;
    if (pos >= 26 && pos < 30) parse_src = parse_src | (32'(b) << (8 * (pos - 26)));
    if (pos >= 30 && pos < 34) parse_dst = parse_dst | (32'(b) << (8 * (pos - 30)));
    // The port pair lands swapped by halves: first two bytes go to the upper half.
    l4 = 14 + 4 * parse_ihl;
    if (pos >= l4 && pos < l4 + 4)
      parse_ports = parse_ports | (32'(b) << (8 * ((pos - l4 + 2) % 4)));
    len = (pos < 65535) ? 16'(pos + 1) : 16'hFFFF;
    parse_offset = len;
    if (last) begin
      lanes = (cfg_port_count < 2) ? 2 : (cfg_port_count > PORT_LIMIT) ? PORT_LIMIT
                                                                    : cfg_port_count;
      if (cfg_flow_hash == BALANCE_FLOW_HASH) begin
        flow = '0;
        if (parse_ether_type == ETHERTYPE_IPV4) begin
          flow = parse_src ^ parse_dst;
          if (parse_proto == PROTO_TCP || parse_proto == PROTO_UDP) flow = flow ^ parse_ports;
          flow = flow * GOLDEN_RATIO_MULT;
        end
        res.port = 3'(flow % lanes);
      end else begin
        res.port = 3'(rr_rotor % lanes);
        rr_rotor = rr_rotor + 1;
      end
      total_frames = total_frames + 48'd1;
      total_bytes = total_bytes + 48'(len);
      res.len = len;
      res.frames = total_frames;
      res.bytes = total_bytes;
      pending_results.push_back(res);
      parse_offset = '0;
      parse_ether_type = '0;
      parse_ihl = '0;
      parse_proto = '0;
      parse_src = '0;
      parse_dst = '0;
      parse_ports = '0;
    end
  endfunction

  // Print one line per mismatch, up to a cap, and count all of them.
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED_MISMATCHES)
      $display("[%0t] mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               $time, what, results_checked, got, want);
  endtask

  // Track accepted input beats and check every accepted result beat.
  always @(posedge clk_i) begin : beat_monitor
    frame_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) absorb_frame_byte(frame_byte_i, frame_end_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no frame pending", 48'(chosen_port_o), '0);
        end else begin
          want = pending_results.pop_front();
          if (chosen_port_o !== want.port)
            report_mismatch("chosen_port", 48'(chosen_port_o), 48'(want.port));
          if (frame_length_o !== want.len)
            report_mismatch("frame_length", 48'(frame_length_o), 48'(want.len));
          if (frames_seen_o !== want.frames)
            report_mismatch("frames_seen", frames_seen_o, want.frames);
          if (bytes_seen_o !== want.bytes)
            report_mismatch("bytes_seen", bytes_seen_o, want.bytes);
        end
        results_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               pending_results.size());
      $display("** flow_hash_load_balancer_unit: FAILED **");
      $finish;
    end
  end

  // Receiver side: random stalls, plus a long hold whenever one is asked for.
  initial begin : rx_stall_driver
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (rx_holds_asked != holds_served) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else begin
        out_ready_i <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one byte beat, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_byte_i <= b;
    frame_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  function automatic void build_random_frame(input int unsigned len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom_range(255)));
  endfunction

  // Random bytes with an IPv4 ether type, header length and protocol patched in.
  function automatic void build_ipv4_frame(input int unsigned ihl, input logic [7:0] proto,
                                           input int unsigned len);
    build_random_frame(len);
    if (len > 12) frame_buf[12] = ETHERTYPE_IPV4[15:8];
    if (len > 13) frame_buf[13] = ETHERTYPE_IPV4[7:0];
    if (len > 14) frame_buf[14] = (frame_buf[14] & 8'hF0) | 8'(ihl & 4'hF);
    if (len > 23) frame_buf[23] = proto;
  endfunction

  // Stop sending, wait for every pending result, then let the back end settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BALANCE_MODE: cfg_flow_hash = value[0];
      REG_PORT_COUNT:   cfg_port_count = value[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [3:0] count);
    wait_idle();
    write_reg(REG_BALANCE_MODE, 32'(mode));
    write_reg(REG_PORT_COUNT, 32'(count));
  endtask

  // Round robin over single-byte frames, including port counts that need clamping.
  task automatic test_round_robin_directed();
    configure(BALANCE_ROUND_ROBIN, 4'd2);
    build_random_frame(1);
    frame_buf[0] = 8'h00;
    send_frame();
    frame_buf[0] = 8'hFF;
    send_frame();
    configure(BALANCE_ROUND_ROBIN, 4'd0);
    repeat (2) send_frame();
    configure(BALANCE_ROUND_ROBIN, 4'd1);
    send_frame();
    configure(BALANCE_ROUND_ROBIN, 4'd15);
    repeat (3) send_frame();
    configure(BALANCE_ROUND_ROBIN, 4'd3);
    repeat (2) send_frame();
  endtask

  // Flow hash on hand-picked header layouts, then a check that the rotor held still.
  task automatic test_flow_hash_directed();
    configure(BALANCE_FLOW_HASH, 4'd8);
    // A 13-byte frame whose ether type high byte alone makes it IPv4.
    build_random_frame(13);
    frame_buf[12] = ETHERTYPE_IPV4[15:8];
    send_frame();
    build_ipv4_frame(5, PROTO_TCP, 40);
    send_frame();
    build_ipv4_frame(5, PROTO_UDP, 42);
    send_frame();
    // Header length zero puts the port bytes right on top of the IP header.
    build_ipv4_frame(0, PROTO_TCP, 40);
    send_frame();
    // Port bytes captured before the protocol byte arrives.
    build_ipv4_frame(1, PROTO_UDP, 40);
    send_frame();
    build_ipv4_frame(2, PROTO_UDP, 40);
    send_frame();
    build_ipv4_frame(15, PROTO_TCP, 78);
    send_frame();
    build_ipv4_frame(5, PROTO_ICMP, 36);
    send_frame();
    build_random_frame(20);
    frame_buf[12] = 8'h86;
    frame_buf[13] = 8'hDD;
    send_frame();
    // Frame cut off inside the destination address.
    build_ipv4_frame(5, PROTO_TCP, 31);
    send_frame();
    configure(BALANCE_FLOW_HASH, 4'd0);
    build_ipv4_frame(5, PROTO_UDP, 38);
    send_frame();
    configure(BALANCE_ROUND_ROBIN, 4'd5);
    build_random_frame(2);
    repeat (2) send_frame();
  endtask

  // Mixed traffic: mostly well-formed IPv4 with random content, plus broken frames and noise.
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned ihl;
    int unsigned l4_end;
    logic [7:0]  proto;
    kind = $urandom_range(99);
    if (kind < 50) begin
      case ($urandom_range(9))
        0:       ihl = $urandom_range(4);
        1, 2, 3: ihl = $urandom_range(15, 6);
        default: ihl = 5;
      endcase
      case ($urandom_range(4))
        0, 1:    proto = PROTO_TCP;
        2, 3:    proto = PROTO_UDP;
        default: proto = 8'($urandom_range(255));
      endcase
      l4_end = 18 + 4 * ihl;
      build_ipv4_frame(ihl, proto, ((l4_end > 34) ? l4_end : 34) + $urandom_range(12));
    end else if (kind < 62) begin
      build_ipv4_frame($urandom_range(15), PROTO_UDP, $urandom_range(40, 13));
    end else if (kind < 78) begin
      build_random_frame($urandom_range(60, 14));
      // Near misses on the IPv4 ether type now and then.
      if ($urandom_range(1)) begin
        frame_buf[12] = ETHERTYPE_IPV4[15:8];
        frame_buf[13] = 8'h01 << $urandom_range(7);
      end
    end else begin
      build_random_frame($urandom_range(12, 1));
    end
    send_frame();
  endtask

  // Two segments of random traffic, one per balance mode, each with its own port count.
  task automatic test_random_traffic(input int unsigned first_segment);
    int unsigned seg;
    int unsigned seg_bytes;
    logic [3:0]  count;
    for (seg = first_segment; seg < first_segment + 2; seg++) begin
      case (seg)
        0:       count = 4'd15;
        1:       count = 4'd0;
        2:       count = 4'd8;
        3:       count = 4'd2;
        4:       count = 4'($urandom_range(7, 3));
        default: count = 4'($urandom_range(15));
      endcase
      configure(seg[0] ? BALANCE_FLOW_HASH : BALANCE_ROUND_ROBIN, count);
      seg_bytes = bytes_sent;
      while (bytes_sent - seg_bytes < SEGMENT_BYTES) send_random_frame();
    end
  endtask

  // Hold the receiver off while a burst of short frames fills the queue and stalls input.
  task automatic test_backpressure();
    configure(1'($urandom_range(1)), 4'd4);
    rx_holds_asked++;
    repeat (14) begin
      build_random_frame($urandom_range(6, 2));
      send_frame();
    end
    wait_idle();
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_round_robin_directed();
    test_flow_hash_directed();
    tx_idle_pct = 29;
    rx_idle_pct = 75;
    test_random_traffic(0);
    tx_idle_pct = 75;
    rx_idle_pct = 29;
    test_random_traffic(2);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(4);
    test_backpressure();
    wait_idle();
    $display("Checked %0d frame results over %0d bytes in both balance modes, port counts",
             results_checked, bytes_sent);
    $display("0 to 15, sender and receiver stalls and a long receiver hold that fills the queue.");
    if (mismatches == 0) begin
      $display("** flow_hash_load_balancer_unit: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** flow_hash_load_balancer_unit: FAILED **");
    end
    $finish;
  end

endmodule
